FILE: rtl/cps_pkg.sv
// Shared types and codes of the process scheduler.
package cps_pkg;

  typedef enum logic [2:0] {
    ST_EMPTY   = 3'd0,
    ST_PEND    = 3'd1,
    ST_READY   = 3'd2,
    ST_DEMOTED = 3'd3,
    ST_IO      = 3'd4,
    ST_DONE    = 3'd5
  } st_t;

  localparam logic [2:0] MODE_FCFS    = 3'd0;
  localparam logic [2:0] MODE_SJF_NP  = 3'd1;
  localparam logic [2:0] MODE_SJF_P   = 3'd2;
  localparam logic [2:0] MODE_PRIO_NP = 3'd3;
  localparam logic [2:0] MODE_PRIO_P  = 3'd4;
  localparam logic [2:0] MODE_RR      = 3'd5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic       admit;
    logic       exec;
    logic [2:0] mode;
    logic [7:0] quantum;
  } ctl_t;

endpackage

FILE: rtl/cps_req_if.sv
// Input channel: load and tick items.
interface cps_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [3:0]  slot;
  logic [7:0]  burst_len;
  logic [7:0]  io_len;
  logic [7:0]  io_point;
  logic [15:0] arrive_at;
  logic [3:0]  prio;

  modport source (output valid, opcode, slot, burst_len, io_len, io_point, arrive_at, prio,
                  input ready);
  modport sink (input valid, opcode, slot, burst_len, io_len, io_point, arrive_at, prio,
                output ready);
endinterface

FILE: rtl/cps_rsp_if.sv
// Output channel: one result item per tick.
interface cps_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  running_id;
  logic        finished;
  logic [15:0] turnaround;
  logic [15:0] wait_time;
  logic        all_done;

  modport source (output valid, running_id, finished, turnaround, wait_time, all_done,
                  input ready);
  modport sink (input valid, running_id, finished, turnaround, wait_time, all_done,
                output ready);
endinterface

FILE: rtl/cpu_process_scheduler.sv
// Top level of the process scheduler: sequencer, cell row and ports.
//
// req carries load and tick items, rsp one result item per tick; a load
// gives no result. Both use valid/ready and move an item when both are high.
// A load is taken in the idle state and req stays ready. A tick passes from
// acceptance to result through the admission state, the selection state while
// the minimum travels along the row of cells, the state that runs the chosen
// entry and the one that forms the result. The next item is taken once the
// result is in the output register, so one tick never overlaps the next.
// If rsp stalls, the result waits in the output register; a further tick
// runs and then holds before its own result until the register is free.
// sched_mode sits at byte address 0 and quantum at 4 on the APB port.
// Reset empties the table, clears the clock and the lock, and sets
// sched_mode to FCFS and quantum to 4. No clearing pass is needed.
module cpu_process_scheduler import cps_pkg::*; #(
  parameter int MAX_PROCS  = 15,
  parameter int TIME_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  cps_req_if.sink     req,
  cps_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TW = TIME_WIDTH;
  localparam int IW = $clog2(MAX_PROCS + 1);
  localparam int CW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ADMIT = 5'b00010,
    S_SEL   = 5'b00100,
    S_EXEC  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t        state;
  logic [2:0]    mode;
  logic [7:0]    quantum;
  logic [TW-1:0] now, nxt;
  logic [IW-1:0] locked, pick;
  logic [CW-1:0] cnt;
  ctl_t          ctl;
  logic          nonpre, lk_rdy, load, slot_ok, sel_last, sel_fin, all_done_c;
  logic [7:0]    sel_obur, sel_iolen;
  logic [TW-1:0] sel_oarr, diff;
  logic [31:0]   diff32;
  logic [15:0]   ta, wt;
  logic [IW-1:0] res_id;
  logic          res_fin;
  logic [15:0]   res_ta, res_wt;

  logic          vp  [0:MAX_PROCS];
  logic [IW-1:0] idp [0:MAX_PROCS];
  logic [TW-1:0] kp  [0:MAX_PROCS];
  logic          va  [0:MAX_PROCS];
  logic [IW-1:0] ida [0:MAX_PROCS];
  logic [TW-1:0] ka  [0:MAX_PROCS];
  st_t           st_a   [1:MAX_PROCS];
  logic          last_a [1:MAX_PROCS];
  logic [7:0]    obur_a [1:MAX_PROCS];
  logic [7:0]    iol_a  [1:MAX_PROCS];
  logic [TW-1:0] oarr_a [1:MAX_PROCS];

  assign vp[0]  = 1'b0;
  assign idp[0] = '0;
  assign kp[0]  = '0;
  assign va[0]  = 1'b0;
  assign ida[0] = '0;
  assign ka[0]  = '0;

  assign pready    = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign nxt       = now + TW'(1);
  assign nonpre    = !(mode == MODE_SJF_P || mode == MODE_PRIO_P || mode == MODE_RR);
  assign slot_ok   = (req.slot != 4'd0) && (32'(req.slot) <= 32'(MAX_PROCS));
  assign load      = req.valid && req.ready && req.opcode == OP_LOAD && slot_ok &&
                     req.burst_len != 8'd0;

  assign ctl.admit   = (state == S_ADMIT);
  assign ctl.exec    = (state == S_EXEC);
  assign ctl.mode    = mode;
  assign ctl.quantum = quantum;

  for (genvar i = 1; i <= MAX_PROCS; i++) begin : g_cell
    cps_cell #(.TW(TW), .IW(IW), .IDX(IW'(i))) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .now       (now),
      .load      (load && IW'(req.slot) == IW'(i)),
      .burst_len (req.burst_len),
      .io_len    (req.io_len),
      .io_point  (req.io_point),
      .arrive    (TW'(req.arrive_at)),
      .prio      (req.prio),
      .picked    (ctl.exec && pick == IW'(i)),
      .vp_in     (vp[i-1]),
      .idp_in    (idp[i-1]),
      .kp_in     (kp[i-1]),
      .va_in     (va[i-1]),
      .ida_in    (ida[i-1]),
      .ka_in     (ka[i-1]),
      .vp_out    (vp[i]),
      .idp_out   (idp[i]),
      .kp_out    (kp[i]),
      .va_out    (va[i]),
      .ida_out   (ida[i]),
      .ka_out    (ka[i]),
      .st        (st_a[i]),
      .last_unit (last_a[i]),
      .obur      (obur_a[i]),
      .iolen     (iol_a[i]),
      .oarr      (oarr_a[i])
    );
  end

  always_comb begin
    lk_rdy     = 1'b0;
    sel_last   = 1'b0;
    sel_obur   = '0;
    sel_iolen  = '0;
    sel_oarr   = '0;
    all_done_c = 1'b1;
    for (int i = 1; i <= MAX_PROCS; i++) begin
      if (locked == IW'(i) && (st_a[i] == ST_READY || st_a[i] == ST_DEMOTED))
        lk_rdy = 1'b1;
      if (st_a[i] != ST_EMPTY && st_a[i] != ST_DONE)
        all_done_c = 1'b0;
    end
    for (int i = 1; i <= MAX_PROCS; i++) begin
      if (pick == IW'(i)) begin
        sel_last  = last_a[i];
        sel_obur  = obur_a[i];
        sel_iolen = iol_a[i];
        sel_oarr  = oarr_a[i];
      end
    end
  end

  always_comb begin
    if (nonpre && lk_rdy)
      pick = locked;
    else if (mode == MODE_RR && vp[MAX_PROCS])
      pick = idp[MAX_PROCS];
    else if (va[MAX_PROCS])
      pick = ida[MAX_PROCS];
    else
      pick = '0;
  end

  assign sel_fin = (pick != '0) && sel_last;
  assign diff    = nxt - sel_oarr;
  assign diff32  = 32'(diff);
  assign ta      = diff32[15:0];
  assign wt      = ta - 16'(sel_obur) - 16'(sel_iolen);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      now     <= '0;
      locked  <= '0;
      cnt     <= '0;
      mode    <= MODE_FCFS;
      quantum <= 8'd4;
      rsp.valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[2])
          REG_MODE:    mode    <= pwdata[2:0];
          REG_QUANTUM: quantum <= pwdata[7:0];
          default: ;
        endcase
      end
      // the result state refills the register itself
      if (rsp.valid && rsp.ready && state != S_FIN)
        rsp.valid <= 1'b0;
      if (load && locked == IW'(req.slot))
        locked <= '0;
      case (state)
        S_IDLE: begin
          if (req.valid && req.opcode == OP_TICK)
            state <= S_ADMIT;
        end
        S_ADMIT: begin
          cnt   <= '0;
          state <= S_SEL;
        end
        S_SEL: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(MAX_PROCS - 1))
            state <= S_EXEC;
        end
        S_EXEC: begin
          if (nonpre && !lk_rdy)
            locked <= pick;
          now   <= nxt;
          state <= S_FIN;
        end
        S_FIN: begin
          // drop the lock once its entry has left for I/O or finished
          if (!lk_rdy)
            locked <= '0;
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_id  <= pick;
      res_fin <= sel_fin;
      res_ta  <= sel_fin ? ta : 16'd0;
      res_wt  <= sel_fin ? wt : 16'd0;
    end
    if (state == S_FIN && (!rsp.valid || rsp.ready)) begin
      rsp.running_id <= 4'(res_id);
      rsp.finished   <= res_fin;
      rsp.turnaround <= res_ta;
      rsp.wait_time  <= res_wt;
      rsp.all_done   <= all_done_c;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:    prdata = {29'd0, mode};
      REG_QUANTUM: prdata = {24'd0, quantum};
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: rtl/cps_cell.sv
// One process table entry with its stage of the selection chain.
module cps_cell import cps_pkg::*; #(
  parameter int TW = 16,
  parameter int IW = 4,
  parameter logic [IW-1:0] IDX = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  ctl_t          ctl,
  input  logic [TW-1:0] now,
  input  logic          load,
  input  logic [7:0]    burst_len,
  input  logic [7:0]    io_len,
  input  logic [7:0]    io_point,
  input  logic [TW-1:0] arrive,
  input  logic [3:0]    prio,
  input  logic          picked,
  input  logic          vp_in,
  input  logic [IW-1:0] idp_in,
  input  logic [TW-1:0] kp_in,
  input  logic          va_in,
  input  logic [IW-1:0] ida_in,
  input  logic [TW-1:0] ka_in,
  output logic          vp_out,
  output logic [IW-1:0] idp_out,
  output logic [TW-1:0] kp_out,
  output logic          va_out,
  output logic [IW-1:0] ida_out,
  output logic [TW-1:0] ka_out,
  output st_t           st,
  output logic          last_unit,
  output logic [7:0]    obur,
  output logic [7:0]    iolen,
  output logic [TW-1:0] oarr
);

  logic [7:0]    rem, iopt, ex, sl, rem_d, ex_d, sl_d;
  logic [7:0]    rem_next, ex_next, sl_next;
  logic [TW-1:0] rt, rt_next, key, nxt;
  logic [3:0]    pri;
  logic          iod, iod_next, rdy, plain;
  st_t           st_next;

  assign nxt       = now + TW'(1);
  assign rem_d     = rem - 8'd1;
  assign ex_d      = ex + 8'd1;
  assign sl_d      = sl + 8'd1;
  assign last_unit = (rem == 8'd1);
  assign rdy       = (st == ST_READY) || (st == ST_DEMOTED);
  assign plain     = (st == ST_READY);

  always_comb begin
    case (ctl.mode) inside
      MODE_SJF_NP, MODE_SJF_P:   key = TW'(rem);
      MODE_PRIO_NP, MODE_PRIO_P: key = TW'(pri);
      default:                   key = rt;
    endcase
  end

  always_comb begin
    st_next  = st;
    rt_next  = rt;
    rem_next = rem;
    ex_next  = ex;
    sl_next  = sl;
    iod_next = iod;
    if (ctl.admit) begin
      if (st == ST_PEND && rt <= now) begin
        st_next = ST_READY;
        if (iolen != 8'd0 && !iod && ex == iopt && rem != 8'd0) begin
          st_next  = ST_IO;
          iod_next = 1'b1;
          rt_next  = now + TW'(iolen);
          sl_next  = 8'd0;
        end
      end else if (st == ST_IO && rt <= now) begin
        st_next = ST_READY;
      end
    end else if (ctl.exec) begin
      // release a demoted entry once its wait has passed
      if (ctl.mode == MODE_RR && st == ST_DEMOTED &&
          {1'b0, now} > ({1'b0, rt} + (TW+1)'(ctl.quantum)))
        st_next = ST_READY;
      if (picked) begin
        rem_next = rem_d;
        ex_next  = ex_d;
        sl_next  = sl_d;
        if (rem_d == 8'd0) begin
          st_next = ST_DONE;
        end else if (iolen != 8'd0 && !iod && ex_d == iopt) begin
          st_next  = ST_IO;
          iod_next = 1'b1;
          rt_next  = nxt + TW'(iolen);
          sl_next  = 8'd0;
        end else if (ctl.mode == MODE_RR && sl_d == ctl.quantum) begin
          st_next = ST_DEMOTED;
          rt_next = nxt;
          sl_next = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_EMPTY;
      iod <= 1'b0;
    end else if (load) begin
      st  <= ST_PEND;
      iod <= 1'b0;
    end else begin
      st  <= st_next;
      iod <= iod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= burst_len;
      obur  <= burst_len;
      iolen <= io_len;
      iopt  <= io_point;
      rt    <= arrive;
      oarr  <= arrive;
      pri   <= prio;
      ex    <= 8'd0;
      sl    <= 8'd0;
    end else begin
      rem <= rem_next;
      ex  <= ex_next;
      sl  <= sl_next;
      rt  <= rt_next;
    end
  end

  // Running minimum moves one cell per cycle; strict compare keeps the lower slot on ties.
  always_ff @(posedge clk) begin
    if (rst) begin
      vp_out <= 1'b0;
      va_out <= 1'b0;
    end else begin
      vp_out <= vp_in || plain;
      va_out <= va_in || rdy;
    end
  end

  always_ff @(posedge clk) begin
    if (plain && (!vp_in || key < kp_in)) begin
      idp_out <= IDX;
      kp_out  <= key;
    end else begin
      idp_out <= idp_in;
      kp_out  <= kp_in;
    end
    if (rdy && (!va_in || key < ka_in)) begin
      ida_out <= IDX;
      ka_out  <= key;
    end else begin
      ida_out <= ida_in;
      ka_out  <= ka_in;
    end
  end

endmodule

FILE: rtl/cps_chk.sv
// Port-level checks for the process scheduler, bound to the top level.
module cps_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_id,
  input logic        out_fin,
  input logic [15:0] out_ta,
  input logic [15:0] out_wt
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_opcode |=> !in_ready)
    else $error("new item taken while a tick is at work");

  a_idle_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fin |-> out_id != 4'd0)
    else $error("completion reported for idle tick");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_fin |-> out_ta == 16'd0 && out_wt == 16'd0)
    else $error("figures shown without completion");

endmodule

bind cpu_process_scheduler cps_chk u_cps_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .in_opcode (req.opcode),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_id    (rsp.running_id),
  .out_fin   (rsp.finished),
  .out_ta    (rsp.turnaround),
  .out_wt    (rsp.wait_time)
);

FILE: tb/tb.sv
// Self-checking testbench of the process scheduler: scoreboard class and drivers.
`timescale 1ns / 1ps

module tb;
  import cps_pkg::*;

  typedef struct {
    logic        opcode;
    logic [3:0]  slot;
    logic [7:0]  burst_len;
    logic [7:0]  io_len;
    logic [7:0]  io_point;
    logic [15:0] arrive_at;
    logic [3:0]  prio;
  } job_t;

  typedef struct {
    logic [3:0]  running_id;
    logic        finished;
    logic [15:0] turnaround;
    logic [15:0] wait_time;
    logic        all_done;
  } tick_res_t;

  // Table of processes kept alongside the block, and the tick results it owes.
  class sched_board;
    logic [7:0]  rem[16], orig[16], iolen[16], iopt[16], execu[16], slc[16];
    logic [15:0] rdy[16], arr[16];
    logic [3:0]  pri[16];
    st_t         st[16];
    bit          iodone[16];
    logic [15:0] now;
    int          lock;
    logic [2:0]  mode;
    logic [7:0]  quant;
    bit          last_all_done;
    tick_res_t   owed[$];
    int          mismatches, checked, completions;

    function new();
      for (int i = 0; i < 16; i++) begin
        st[i] = ST_EMPTY;
        iodone[i] = 0;
      end
      now = 0;
      lock = 0;
      mode = MODE_FCFS;
      quant = 8'd4;
      last_all_done = 1;
    endfunction

    function bit is_ready(int i);
      return st[i] == ST_READY || st[i] == ST_DEMOTED;
    endfunction

    function bit io_due(int i);
      return iolen[i] != 0 && !iodone[i] && execu[i] == iopt[i] && rem[i] != 0;
    endfunction

    function void go_io(int i, logic [15:0] at);
      st[i] = ST_IO;
      iodone[i] = 1;
      rdy[i] = at + 16'(iolen[i]);
      slc[i] = 0;
      if (lock == i) lock = 0;
    endfunction

    function int sel_key(int i);
      if (mode == MODE_SJF_NP || mode == MODE_SJF_P) return rem[i];
      if (mode == MODE_PRIO_NP || mode == MODE_PRIO_P) return pri[i];
      return rdy[i];
    endfunction

    function int pick_min(bit plain_only);
      int best, bk;
      best = 0;
      bk = 0;
      for (int i = 1; i <= 15; i++) begin
        if (!is_ready(i)) continue;
        if (plain_only && st[i] != ST_READY) continue;
        if (best == 0 || sel_key(i) < bk) begin
          best = i;
          bk = sel_key(i);
        end
      end
      return best;
    endfunction

    function void set_reg(logic idx, logic [7:0] v);
      if (idx == REG_MODE) mode = v[2:0];
      else quant = v;
    endfunction

    function void note_item(job_t j);
      int s, pick;
      bit nonpre, alld;
      logic [15:0] t, nxt;
      tick_res_t r;
      if (j.opcode == OP_LOAD) begin
        s = j.slot;
        if (s < 1 || j.burst_len == 0) return;
        rem[s] = j.burst_len;
        orig[s] = j.burst_len;
        iolen[s] = j.io_len;
        iopt[s] = j.io_point;
        rdy[s] = j.arrive_at;
        arr[s] = j.arrive_at;
        pri[s] = j.prio;
        execu[s] = 0;
        slc[s] = 0;
        iodone[s] = 0;
        st[s] = ST_PEND;
        if (lock == s) lock = 0;
        return;
      end
      t = now;
      nxt = t + 16'd1;
      nonpre = !(mode == MODE_SJF_P || mode == MODE_PRIO_P || mode == MODE_RR);
      r = '{default: '0};
      for (int i = 1; i <= 15; i++) begin
        if (st[i] == ST_PEND && rdy[i] <= t) begin
          st[i] = ST_READY;
          if (io_due(i)) go_io(i, t);
        end else if (st[i] == ST_IO && rdy[i] <= t) begin
          st[i] = ST_READY;
        end
      end
      if (nonpre && lock >= 1 && is_ready(lock)) begin
        pick = lock;
      end else begin
        pick = pick_min(mode == MODE_RR);
        if (mode == MODE_RR && pick == 0) pick = pick_min(0);
        if (nonpre) lock = pick;
      end
      // release demoted entries only after this tick's choice
      if (mode == MODE_RR) begin
        for (int i = 1; i <= 15; i++)
          if (st[i] == ST_DEMOTED && int'(t) > int'(rdy[i]) + int'(quant)) st[i] = ST_READY;
      end
      if (pick != 0) begin
        rem[pick] = rem[pick] - 8'd1;
        execu[pick] = execu[pick] + 8'd1;
        slc[pick] = slc[pick] + 8'd1;
        if (rem[pick] == 0) begin
          st[pick] = ST_DONE;
          r.finished = 1;
          r.turnaround = nxt - arr[pick];
          r.wait_time = r.turnaround - 16'(orig[pick]) - 16'(iolen[pick]);
          if (lock == pick) lock = 0;
        end else if (io_due(pick)) begin
          go_io(pick, nxt);
        end else if (mode == MODE_RR && slc[pick] == quant) begin
          st[pick] = ST_DEMOTED;
          rdy[pick] = nxt;
          slc[pick] = 0;
        end
      end
      now = nxt;
      alld = 1;
      for (int i = 1; i <= 15; i++)
        if (st[i] != ST_EMPTY && st[i] != ST_DONE) alld = 0;
      r.running_id = 4'(pick);
      r.all_done = alld;
      last_all_done = alld;
      owed.push_back(r);
    endfunction

    function void check_result(tick_res_t a);
      tick_res_t e;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: id %0d fin %0b", a.running_id,
                                       a.finished);
        return;
      end
      e = owed.pop_front();
      checked++;
      if (e.finished) completions++;
      if (a.running_id !== e.running_id || a.finished !== e.finished ||
          a.turnaround !== e.turnaround || a.wait_time !== e.wait_time ||
          a.all_done !== e.all_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tick %0d mismatch: exp id %0d fin %0b ta %0d wt %0d done %0b, got id %0d fin %0b ta %0d wt %0d done %0b",
                   checked, e.running_id, e.finished, e.turnaround, e.wait_time,
                   e.all_done, a.running_id, a.finished, a.turnaround, a.wait_time,
                   a.all_done);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  bit          calm;
  int          cycles, stale, items_sent;
  sched_board  board;

  cps_req_if req ();
  cps_rsp_if rsp ();

  cpu_process_scheduler dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Take results, stall at random, and watch for a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    calm <= (cycles > 10000 && cycles < 16000);
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= calm || ($urandom_range(99) >= 18);
      if (rsp.valid && rsp.ready)
        board.check_result('{rsp.running_id, rsp.finished, rsp.turnaround, rsp.wait_time,
                             rsp.all_done});
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel) stale <= 0;
      else stale <= stale + 1;
      if (stale > 3000) begin
        $display("watchdog: no progress for %0d cycles", stale);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send(job_t j);
    while (!calm && $urandom_range(99) < 18) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= j.opcode;
    req.slot <= j.slot;
    req.burst_len <= j.burst_len;
    req.io_len <= j.io_len;
    req.io_point <= j.io_point;
    req.arrive_at <= j.arrive_at;
    req.prio <= j.prio;
    do @(posedge clk); while (!req.ready);
    board.note_item(j);
    items_sent++;
  endtask

  task automatic tick();
    job_t j;
    j = '{default: '0};
    j.opcode = OP_TICK;
    j.slot = 4'($urandom);
    j.burst_len = 8'($urandom);
    j.io_len = 8'($urandom);
    j.io_point = 8'($urandom);
    j.arrive_at = 16'($urandom);
    j.prio = 4'($urandom);
    send(j);
  endtask

  task automatic load(int s, int b, int io, int pt, int at, int pr);
    send('{OP_LOAD, 4'(s), 8'(b), 8'(io), 8'(pt), 16'(at), 4'(pr)});
  endtask

  // Drain the block, hold off any tick in flight, then write one register.
  task automatic write_reg(logic idx, logic [7:0] v);
    req.valid <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    board.set_reg(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Load a small set of processes near the current time, then run it out.
  task automatic batch();
    int k, b, n;
    k = $urandom_range(5, 1);
    for (int i = 0; i < k; i++) begin
      b = ($urandom_range(19) == 0) ? $urandom_range(255, 1) : $urandom_range(12, 1);
      if ($urandom_range(9) == 0) load(0, b, 3, 1, 0, 0);
      else if ($urandom_range(9) == 0) load($urandom_range(15, 1), 0, 3, 1, 0, 0);
      load($urandom_range(15, 1), b,
           ($urandom_range(2) == 0) ? 0 : (($urandom_range(29) == 0) ? 255
                                          : $urandom_range(12, 1)),
           ($urandom_range(29) == 0) ? $urandom_range(254) : $urandom_range(b + 2),
           ($urandom_range(39) == 0) ? $urandom : board.now + $urandom_range(10),
           $urandom_range(15));
    end
    n = 0;
    while (n < 300) begin
      tick();
      n++;
      if (board.last_all_done) break;
      // occasional reload of an entry while the table is busy
      if ($urandom_range(49) == 0)
        load($urandom_range(15, 1), $urandom_range(8, 1), $urandom_range(4),
             $urandom_range(6), board.now, $urandom_range(15));
    end
  endtask

  initial begin
    logic [2:0] modes[8] = '{MODE_FCFS, MODE_SJF_NP, MODE_SJF_P, MODE_PRIO_NP,
                             MODE_PRIO_P, MODE_RR, MODE_RR, MODE_RR};
    int quanta[8] = '{255, 4, 7, 2, 3, 1, 255, 0};
    board = new();
    rst = 1'b1;
    cycles = 0;
    stale = 0;
    calm = 0;
    items_sent = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.opcode = OP_LOAD;
    req.slot = '0;
    req.burst_len = '0;
    req.io_len = '0;
    req.io_point = '0;
    req.arrive_at = '0;
    req.prio = '0;
    rsp.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, ignored loads, I/O at admission, I/O point past the burst, reload
    load(15, 255, 255, 254, 0, 15);
    load(1, 1, 0, 0, 0, 0);
    load(0, 5, 0, 0, 0, 0);
    load(3, 0, 0, 0, 0, 0);
    load(2, 3, 2, 0, 1, 7);
    load(4, 2, 9, 200, 0, 8);
    load(5, 4, 1, 2, 65535, 3);
    load(5, 4, 1, 2, 2, 3);
    repeat (12) tick();
    load(15, 2, 0, 0, 0, 15);
    repeat (10) tick();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MODE, 8'(modes[ph]));
      write_reg(REG_QUANTUM, 8'(quanta[ph]));
      while (items_sent < (ph + 1) * 250) batch();
    end
    req.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d items over six scheduling modes and several quanta.", items_sent);
    $display("Checked %0d ticks, %0d completions, %0d mismatches.", board.checked,
             board.completions, board.mismatches);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/cps_pkg.sv
rtl/cps_req_if.sv
rtl/cps_rsp_if.sv
rtl/cps_cell.sv
rtl/cpu_process_scheduler.sv
rtl/cps_chk.sv
tb/tb.sv
